FILE: sv/apd_pkg.sv
// Shared types and constants of the ATAPI packet read device.
package apd_pkg;

	localparam int BLOCK_BYTES_DEF  = 2048;
	localparam int PACKET_BYTES_DEF = 12;

	typedef enum logic [2:0] {
		OP_BYTE_RD = 3'd0,
		OP_BYTE_WR = 3'd1,
		OP_WORD_RD = 3'd2,
		OP_WORD_WR = 3'd3,
		OP_FILL    = 3'd4
	} op_t;

	localparam logic [15:0] DATA_PORT   = 16'h01F0;
	localparam logic [15:0] SEC_BASE    = 16'h0170;
	localparam logic [15:0] PORT_SECT   = DATA_PORT + 16'd2;
	localparam logic [15:0] PORT_LBAL   = DATA_PORT + 16'd3;
	localparam logic [15:0] PORT_LBAM   = DATA_PORT + 16'd4;
	localparam logic [15:0] PORT_LBAH   = DATA_PORT + 16'd5;
	localparam logic [15:0] PORT_DRIVE  = DATA_PORT + 16'd6;
	localparam logic [15:0] PORT_STATUS = DATA_PORT + 16'd7;
	localparam logic [15:0] PORT_DRIVE2 = SEC_BASE + 16'd6;

	localparam logic [15:0] SIG_LBAL     = 16'h0001;
	localparam logic [15:0] SIG_LBAM     = 16'h0014;
	localparam logic [15:0] SIG_LBAH     = 16'h00EB;
	localparam logic [15:0] STATUS_DRQ   = 16'h0001 << 3;
	localparam logic [15:0] SC_SIG       = 16'd1;
	localparam logic [15:0] SC_PACKET    = 16'd2;
	localparam logic [15:0] SC_DONE      = 16'd3;
	localparam logic [7:0]  OPC_READ12   = 8'hA8;
	localparam logic [7:0]  DRIVE_MASTER = 8'h00;

endpackage

FILE: sv/apd_buf.sv
// Block buffer memory with post-reset clearing sweep.
module apd_buf
	import apd_pkg::*;
#(
	parameter int WORDS = BLOCK_BYTES_DEF / 2,
	parameter int AW    = $clog2(WORDS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [15:0]   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [15:0]   rd_data,
	output logic          busy
);

	logic [15:0]   mem [WORDS];
	logic          busy_q;
	logic [AW-1:0] clr_addr_q;
	logic [15:0]   rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			if (clr_addr_q == AW'(WORDS - 1)) begin
				busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = busy_q;

	a_no_access_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !wr_en && !rd_en)
		else $error("buffer access during clearing sweep");

	a_sweep_covers_all: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(clr_addr_q) == AW'(WORDS - 1))
		else $error("clearing sweep ended early");

	a_sweep_once: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |=> !busy_q)
		else $error("clearing sweep restarted");

endmodule

FILE: sv/apd_ctrl.sv
// Access decode, device registers, packet store and output stage.
module apd_ctrl
	import apd_pkg::*;
#(
	parameter int BLOCK_BYTES  = BLOCK_BYTES_DEF,
	parameter int PACKET_BYTES = PACKET_BYTES_DEF,
	parameter int WORDS        = (BLOCK_BYTES + 1) / 2,
	parameter int AW           = $clog2(WORDS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [2:0]    op,
	input  logic [15:0]   port,
	input  logic [15:0]   data,
	input  logic [9:0]    fill_index,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [15:0]   read_data,
	output logic          fetch_request,
	output logic [31:0]   fetch_lba,
	output logic          unsupported_opcode,
	output logic          mem_wr_en,
	output logic [AW-1:0] mem_wr_addr,
	output logic [15:0]   mem_wr_data,
	output logic          mem_rd_en,
	output logic [AW-1:0] mem_rd_addr,
	input  logic [15:0]   mem_rd_data,
	input  logic          mem_busy
);

	localparam int SPW = $clog2(BLOCK_BYTES + 2);
	localparam int CW  = $clog2(PACKET_BYTES + 1);
	localparam int PIW = $clog2(PACKET_BYTES);

	logic [7:0]     drive_q;
	logic [7:0]     pkt_q [PACKET_BYTES];
	logic [CW-1:0]  cnt_q;
	logic           recv_q;
	logic           send_q;
	logic [SPW-1:0] sp_q;

	logic           valid_s1;
	logic [15:0]    rd_s1;
	logic           fr_s1;
	logic [31:0]    lba_s1;
	logic           uo_s1;
	logic           memrd_s1;

	logic           acc;
	logic [7:0]     drive_n;
	logic [CW-1:0]  cnt_n;
	logic           recv_n;
	logic           send_n;
	logic [SPW-1:0] sp_n;
	logic           pkt_we;
	logic [15:0]    rd_n;
	logic           fr_n;
	logic [31:0]    lba_n;
	logic           uo_n;
	logic           memrd_n;
	logic [PIW-1:0] pkt_idx0;
	logic [PIW-1:0] pkt_idx1;

	assign in_ready = !mem_busy && (!valid_s1 || out_ready);
	assign acc      = in_valid && in_ready;
	assign pkt_idx0 = cnt_q[PIW-1:0];
	assign pkt_idx1 = PIW'(cnt_q[PIW-1:0] + PIW'(1));

	always_comb begin
		drive_n     = drive_q;
		cnt_n       = cnt_q;
		recv_n      = recv_q;
		send_n      = send_q;
		sp_n        = sp_q;
		pkt_we      = 1'b0;
		rd_n        = '0;
		fr_n        = 1'b0;
		lba_n       = '0;
		uo_n        = 1'b0;
		memrd_n     = 1'b0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = AW'(fill_index);
		mem_wr_data = data;
		mem_rd_en   = 1'b0;
		mem_rd_addr = AW'(sp_q >> 1);
		unique case (op_t'(op))
			OP_BYTE_RD: begin
				if (port >= PORT_SECT && port <= PORT_LBAH) begin
					if (drive_q == DRIVE_MASTER) begin
						unique case (port)
							PORT_SECT: begin
								if (send_q) begin
									sp_n   = '0;
									send_n = 1'b0;
									rd_n   = SC_DONE;
								end else if (recv_q) begin
									if (pkt_q[0] != OPC_READ12) begin
										uo_n = 1'b1;
									end else begin
										fr_n  = 1'b1;
										lba_n = {pkt_q[2], pkt_q[3], pkt_q[4], pkt_q[5]};
										sp_n  = '0;
									end
									cnt_n  = '0;
									recv_n = 1'b0;
									rd_n   = SC_PACKET;
								end else begin
									rd_n = SC_SIG;
								end
							end
							PORT_LBAL: rd_n = SIG_LBAL;
							PORT_LBAM: rd_n = SIG_LBAM;
							PORT_LBAH: rd_n = SIG_LBAH;
							default:   rd_n = '0;
						endcase
					end
				end else if (port == PORT_STATUS) begin
					rd_n = STATUS_DRQ;
				end
			end
			OP_BYTE_WR: begin
				if (port == PORT_DRIVE || port == PORT_DRIVE2) begin
					drive_n = data[7:0];
				end
			end
			OP_WORD_RD: begin
				if (port == DATA_PORT && sp_q < SPW'(BLOCK_BYTES)) begin
					mem_rd_en = acc;
					memrd_n   = 1'b1;
					send_n    = 1'b1;
					sp_n      = sp_q + SPW'(2);
				end
			end
			OP_WORD_WR: begin
				if (port == DATA_PORT
						&& (CW + 1)'(cnt_q) + (CW + 1)'(2) <= (CW + 1)'(PACKET_BYTES)) begin
					recv_n = 1'b1;
					pkt_we = 1'b1;
					cnt_n  = cnt_q + CW'(2);
				end
			end
			OP_FILL: begin
				if (32'(fill_index) < WORDS) begin
					mem_wr_en = acc;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q <= '0;
			cnt_q   <= '0;
			recv_q  <= 1'b0;
			send_q  <= 1'b0;
			sp_q    <= '0;
			for (int i = 0; i < PACKET_BYTES; i++) begin
				pkt_q[i] <= '0;
			end
		end else if (acc) begin
			drive_q <= drive_n;
			cnt_q   <= cnt_n;
			recv_q  <= recv_n;
			send_q  <= send_n;
			sp_q    <= sp_n;
			if (pkt_we) begin
				pkt_q[pkt_idx0] <= data[7:0];
				pkt_q[pkt_idx1] <= data[15:8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (out_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1    <= rd_n;
			fr_s1    <= fr_n;
			lba_s1   <= lba_n;
			uo_s1    <= uo_n;
			memrd_s1 <= memrd_n;
		end
	end

	assign out_valid          = valid_s1;
	assign read_data          = memrd_s1 ? mem_rd_data : rd_s1;
	assign fetch_request      = fr_s1;
	assign fetch_lba          = lba_s1;
	assign unsupported_opcode = uo_s1;

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= PACKET_BYTES && !cnt_q[0])
		else $error("packet count out of range");

	a_send_pos_even: assert property (@(posedge clk) disable iff (!arst_n)
		!sp_q[0] && 32'(sp_q) <= BLOCK_BYTES + 1)
		else $error("send position out of range");

	a_fetch_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !(fr_s1 && uo_s1) && (fr_s1 || lba_s1 == '0))
		else $error("fetch result inconsistent");

	a_stream_sets_send: assert property (@(posedge clk) disable iff (!arst_n)
		acc && memrd_n |=> send_q && memrd_s1)
		else $error("block stream did not mark sending");

endmodule

FILE: sv/atapi_packet_read_device.sv
// Top level of the ATAPI packet read device.
// One bus access or fill word is taken per cycle while in_ready is high, and its
// single result leaves in the next cycle from the output register; the buffer read
// behind a data-port word read is registered alongside that output register. After
// reset the block buffer is swept to zero, one word per cycle, so in_ready stays low
// until all (BLOCK_BYTES + 1) / 2 words (1024 at the default size) are cleared. A
// stalled result holds in_ready low until it is taken or leaves in the same cycle.
module atapi_packet_read_device
	import apd_pkg::*;
#(
	parameter int BLOCK_BYTES  = BLOCK_BYTES_DEF,
	parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [15:0] port,
	input  logic [15:0] data,
	input  logic [9:0]  fill_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] read_data,
	output logic        fetch_request,
	output logic [31:0] fetch_lba,
	output logic        unsupported_opcode
);

	localparam int WORDS = (BLOCK_BYTES + 1) / 2;
	localparam int AW    = $clog2(WORDS);

	logic          mem_wr_en;
	logic [AW-1:0] mem_wr_addr;
	logic [15:0]   mem_wr_data;
	logic          mem_rd_en;
	logic [AW-1:0] mem_rd_addr;
	logic [15:0]   mem_rd_data;
	logic          mem_busy;

	apd_ctrl #(
		.BLOCK_BYTES  (BLOCK_BYTES),
		.PACKET_BYTES (PACKET_BYTES),
		.WORDS        (WORDS),
		.AW           (AW)
	) u_ctrl (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.op                 (op),
		.port               (port),
		.data               (data),
		.fill_index         (fill_index),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.read_data          (read_data),
		.fetch_request      (fetch_request),
		.fetch_lba          (fetch_lba),
		.unsupported_opcode (unsupported_opcode),
		.mem_wr_en          (mem_wr_en),
		.mem_wr_addr        (mem_wr_addr),
		.mem_wr_data        (mem_wr_data),
		.mem_rd_en          (mem_rd_en),
		.mem_rd_addr        (mem_rd_addr),
		.mem_rd_data        (mem_rd_data),
		.mem_busy           (mem_busy)
	);

	apd_buf #(
		.WORDS (WORDS),
		.AW    (AW)
	) u_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.busy    (mem_busy)
	);

endmodule
